// ----- hw/rtl/vds_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vds_pkg
// Shared widths, constants and types of the directional strain block.
// ----------------------------------------------------------------------------
package vds_pkg;

   // ring and field widths
   localparam int MAX_RING = 16;
   localparam int CNT_W    = 7;
   localparam int POS_W    = 32;
   localparam int FRAC_W   = 16;
   localparam int PROD_W   = 2 * POS_W;
   localparam int FLQ_W    = PROD_W - FRAC_W;
   localparam int PROJ_W   = 50;
   localparam int LEN2_W   = 48;
   localparam int MAG_W    = 50;
   localparam int T_W      = 57;
   localparam int SUM_W    = 40;
   localparam int FEED_W   = 40;
   localparam int QUO_W    = 40;
   localparam int DIV_STEP_W = 6;

   // strain division: remainder preload from the upper bits, rest fed serially
   localparam int STRAIN_FEED_BITS = 15;
   localparam int MAC_LAST         = 9;

   localparam logic [DIV_STEP_W-1:0] STRAIN_STEPS = DIV_STEP_W'(31);
   localparam logic [DIV_STEP_W-1:0] MEAN_STEPS   = DIV_STEP_W'(40);

   localparam logic [POS_W-1:0] S32_MAX    = 32'h7FFF_FFFF;
   localparam logic [POS_W-1:0] S32_MIN    = 32'h8000_0000;
   localparam logic [POS_W-1:0] AXIS_Z_RST = 32'h0001_0000;
   localparam logic [SUM_W-1:0] SUM_MAX    = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] SUM_MIN    = {1'b1, {(SUM_W-1){1'b0}}};

   // item kinds on req_tuser
   localparam logic REQ_CENTRE    = 1'b0;
   localparam logic REQ_NEIGHBOUR = 1'b1;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_AXIS_X = 2'd0,
      CSR_AXIS_Y = 2'd1,
      CSR_AXIS_Z = 2'd2
   } csr_idx_type;

   // command to the serial divider
   typedef struct packed {
      logic                  start;
      logic [DIV_STEP_W-1:0] steps;
      logic [MAG_W-1:0]      rem_init;
      logic [FEED_W-1:0]     feed;
      logic [MAG_W-1:0]      den;
   } div_cmd_type;

   // status of the serial divider
   typedef struct packed {
      logic             busy;
      logic             done;
      logic [QUO_W-1:0] quo;
   } div_sts_type;

   // projections of one neighbour
   typedef struct packed {
      logic signed [PROJ_W-1:0] pd;
      logic signed [PROJ_W-1:0] pe;
      logic [LEN2_W-1:0]        len2;
   } proj_res_type;

endpackage
`default_nettype wire

// ----- hw/rtl/vds_proj.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vds_proj
// Displacements of one neighbour and their projections on the axis, with one
// shared multiplier stepping through the nine products.
// ----------------------------------------------------------------------------
module vds_proj
   import vds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2:0][POS_W-1:0] nb_ed,
   input  logic [2:0][POS_W-1:0] nb_es,
   input  logic [2:0][POS_W-1:0] c_ed,
   input  logic [2:0][POS_W-1:0] c_es,
   input  logic [2:0][POS_W-1:0] axis,
   output logic                  done,
   output logic                  clip,
   output proj_res_type          res
);

   typedef enum logic {
      P_IDLE,
      P_MAC
   } pstate_type;

   typedef enum logic [1:0] {
      G_PD,
      G_PE,
      G_LEN
   } grp_type;

   // difference clamped to 32 bits, overflow flag on top
   function automatic logic [POS_W:0] sat_sub(input logic [POS_W-1:0] a,
                                             input logic [POS_W-1:0] b);
      logic [POS_W:0] d;
      d = {a[POS_W-1], a} - {b[POS_W-1], b};
      if (d[POS_W] != d[POS_W-1]) begin
         sat_sub = {1'b1, (d[POS_W] ? S32_MIN : S32_MAX)};
      end else begin
         sat_sub = {1'b0, d[POS_W-1:0]};
      end
   endfunction

   pstate_type               state_ff;
   logic [3:0]               step_ff;
   logic [2:0][POS_W-1:0]    dd_ff;
   logic [2:0][POS_W-1:0]    de_ff;
   logic                     clip_ff;
   logic                     done_ff;
   logic signed [PROD_W-1:0] prod_ff;
   grp_type                  grp_ff;
   logic signed [PROJ_W-1:0] pd_ff;
   logic signed [PROJ_W-1:0] pe_ff;
   logic [LEN2_W-1:0]        len2_ff;

   logic [2:0][POS_W:0]      ddr;
   logic [2:0][POS_W:0]      der;
   logic                     dclip;
   grp_type                  grp;
   logic [1:0]               lane;
   logic [3:0]               lane_tmp;
   logic [POS_W-1:0]         mul_a;
   logic [POS_W-1:0]         mul_b;
   logic signed [FLQ_W-1:0]  flq;

   // clamped displacements of all three components
   always_comb begin
      dclip = 1'b0;
      for (int i = 0; i < 3; i++) begin
         ddr[i] = sat_sub(nb_ed[i], c_ed[i]);
         der[i] = sat_sub(nb_es[i], c_es[i]);
         dclip  = dclip | ddr[i][POS_W] | der[i][POS_W];
      end
   end

   // operand selection for the current product
   always_comb begin
      lane_tmp = 4'd0;
      grp      = G_PD;
      if (step_ff < 4'd3) begin
         lane_tmp = step_ff;
         grp      = G_PD;
      end else if (step_ff < 4'd6) begin
         lane_tmp = step_ff - 4'd3;
         grp      = G_PE;
      end else begin
         lane_tmp = step_ff - 4'd6;
         grp      = G_LEN;
      end
      lane = lane_tmp[1:0];
      case (grp)
         G_PD:    mul_a = dd_ff[lane];
         G_PE:    mul_a = de_ff[lane];
         G_LEN:   mul_a = axis[lane];
         default: mul_a = dd_ff[lane];
      endcase
      mul_b = axis[lane];
   end

   // floored q32.16 of the registered product
   assign flq = prod_ff[PROD_W-1:FRAC_W];

   // sequencer: diffs, then multiply and accumulate one product a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
         step_ff  <= 4'd0;
         done_ff  <= 1'b0;
         clip_ff  <= 1'b0;
         grp_ff   <= G_PD;
         pd_ff    <= '0;
         pe_ff    <= '0;
         len2_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            P_IDLE: begin
               if (start) begin
                  for (int i = 0; i < 3; i++) begin
                     dd_ff[i] <= ddr[i][POS_W-1:0];
                     de_ff[i] <= der[i][POS_W-1:0];
                  end
                  clip_ff  <= dclip;
                  pd_ff    <= '0;
                  pe_ff    <= '0;
                  len2_ff  <= '0;
                  step_ff  <= 4'd0;
                  state_ff <= P_MAC;
               end
            end
            P_MAC: begin
               if (step_ff < 4'(MAC_LAST)) begin
                  prod_ff <= $signed(mul_a) * $signed(mul_b);
                  grp_ff  <= grp;
               end
               if (step_ff != 4'd0) begin
                  case (grp_ff)
                     G_PD:    pd_ff   <= pd_ff + PROJ_W'(flq);
                     G_PE:    pe_ff   <= pe_ff + PROJ_W'(flq);
                     G_LEN:   len2_ff <= len2_ff + prod_ff[PROD_W-1:FRAC_W];
                     default: pd_ff   <= pd_ff;
                  endcase
               end
               if (step_ff == 4'(MAC_LAST)) begin
                  done_ff  <= 1'b1;
                  state_ff <= P_IDLE;
               end else begin
                  step_ff <= step_ff + 4'd1;
               end
            end
            default: state_ff <= P_IDLE;
         endcase
      end
   end

   assign done     = done_ff;
   assign clip     = clip_ff;
   assign res.pd   = pd_ff;
   assign res.pe   = pe_ff;
   assign res.len2 = len2_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/vds_sdiv.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vds_sdiv
// Restoring divider, one quotient bit a cycle, dividend bits fed MSB first.
// ----------------------------------------------------------------------------
module vds_sdiv
   import vds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_sts_type sts
);

   logic                  busy_ff;
   logic                  done_ff;
   logic [DIV_STEP_W-1:0] cnt_ff;
   logic [MAG_W-1:0]      rem_ff;
   logic [FEED_W-1:0]     feed_ff;
   logic [MAG_W-1:0]      den_ff;
   logic [QUO_W-1:0]      quo_ff;

   logic [MAG_W:0]        r2;
   logic [MAG_W:0]        diff;
   logic                  qbit;

   // one trial subtraction
   always_comb begin
      r2   = {rem_ff, feed_ff[FEED_W-1]};
      diff = r2 - {1'b0, den_ff};
      qbit = (r2 >= {1'b0, den_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         quo_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= cmd.steps;
            rem_ff  <= cmd.rem_init;
            feed_ff <= cmd.feed;
            den_ff  <= cmd.den;
            quo_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff  <= qbit ? diff[MAG_W-1:0] : r2[MAG_W-1:0];
            quo_ff  <= {quo_ff[QUO_W-2:0], qbit};
            feed_ff <= {feed_ff[FEED_W-2:0], 1'b0};
            cnt_ff  <= cnt_ff - DIV_STEP_W'(1);
            if (cnt_ff == DIV_STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign sts.quo  = quo_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/vertex_directional_strain.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_directional_strain
// Mean strain of one mesh vertex along a configured axis.
// ----------------------------------------------------------------------------
// A centre item (req_tuser = 0) loads the vertex positions and clears the
// running sum; with req_tlast set it answers at once with ring_empty.
// Neighbour items (req_tuser = 1) follow; the one with req_tlast set closes
// the ring and produces one result item on the rsp channel.
// A neighbour passes through the shared multiplier over nine products,
// the compare and scaling steps, the bit-serial strain division and the
// accumulate step before it returns to idle. Skipped neighbours leave out
// scaling, division and accumulation, those with a saturated strain the
// division, capped ones all but the final step. The last neighbour adds
// the bit-serial mean division by the neighbour count.
// The csr port holds the axis; write it only while the block is idle.
// Reset sets the axis to (0, 0, 1.0) and clears centre and accumulators.
// The result sits in an output register: a new item is taken while it
// waits, and the block holds in its emit step only when a second result
// is ready before rsp_tready takes the first.
// ----------------------------------------------------------------------------
module vertex_directional_strain
   import vds_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // input items
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [191:0] req_tdata,   // ed_x, ed_y, ed_z, es_x, es_y, es_z
   input  logic         req_tuser,   // req_type
   input  logic         req_tlast,   // last_neighbour
   // result items
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // strain_percent
   output logic [1:0]   rsp_tuser,   // ring_empty, clipped
   // configuration
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_PROJ,
      S_ABS,
      S_PREP,
      S_SCALE,
      S_CHK,
      S_SDIV,
      S_ACC,
      S_FIN,
      S_MDIV,
      S_EMIT
   } state_type;

   state_type             state_ff;
   logic [2:0][POS_W-1:0] axis_ff;
   logic [2:0][POS_W-1:0] c_ed_ff;
   logic [2:0][POS_W-1:0] c_es_ff;
   logic [2:0][POS_W-1:0] n_ed_ff;
   logic [2:0][POS_W-1:0] n_es_ff;
   logic                  last_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  clip_ff;
   logic                  proj_start_ff;
   logic [MAG_W-1:0]      apd_ff;
   logic [MAG_W-1:0]      ape_ff;
   logic [MAG_W-1:0]      mag_ff;
   logic                  neg_ff;
   logic [T_W-1:0]        t_ff;
   logic                  sat_ff;
   logic                  res_zero_ff;
   logic                  res_empty_ff;
   logic                  res_neg_ff;
   logic                  rsp_valid_ff;
   logic [POS_W-1:0]      rsp_data_ff;
   logic [1:0]            rsp_user_ff;

   logic                  proj_done;
   logic                  proj_clip;
   proj_res_type          proj_res;
   div_cmd_type           div_cmd;
   div_sts_type           div_sts;

   logic                  req_acc;
   logic                  out_free;
   logic [MAG_W-1:0]      pd_abs;
   logic [MAG_W-1:0]      pe_abs;
   logic [T_W-1:0]        apd_x100;
   logic [T_W-1:0]        mag_x100;
   logic                  big;
   logic [SUM_W-1:0]      sum_abs;
   logic [POS_W-1:0]      strain;
   logic [SUM_W:0]        sum_next;
   logic [QUO_W-1:0]      mean;

   // projection unit
   vds_proj u_proj (
      .clock (clock),
      .reset (reset),
      .start (proj_start_ff),
      .nb_ed (n_ed_ff),
      .nb_es (n_es_ff),
      .c_ed  (c_ed_ff),
      .c_es  (c_es_ff),
      .axis  (axis_ff),
      .done  (proj_done),
      .clip  (proj_clip),
      .res   (proj_res)
   );

   // shared serial divider
   vds_sdiv u_sdiv (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .sts   (div_sts)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // magnitudes, scaled values and the saturation test
   always_comb begin
      pd_abs   = proj_res.pd[PROJ_W-1] ? MAG_W'(-proj_res.pd) : MAG_W'(proj_res.pd);
      pe_abs   = proj_res.pe[PROJ_W-1] ? MAG_W'(-proj_res.pe) : MAG_W'(proj_res.pe);
      apd_x100 = (T_W'(apd_ff) << 6) + (T_W'(apd_ff) << 5) + (T_W'(apd_ff) << 2);
      mag_x100 = (T_W'(mag_ff) << 6) + (T_W'(mag_ff) << 5) + (T_W'(mag_ff) << 2);
      big      = ({8'd0, t_ff} >= {apd_ff, {STRAIN_FEED_BITS{1'b0}}});
      sum_abs  = sum_ff[SUM_W-1] ? (~sum_ff + SUM_W'(1)) : sum_ff;
      if (sat_ff) begin
         strain = S32_MAX;
      end else if (neg_ff) begin
         strain = ~div_sts.quo[POS_W-1:0] + POS_W'(1);
      end else begin
         strain = div_sts.quo[POS_W-1:0];
      end
      sum_next = {sum_ff[SUM_W-1], sum_ff} + {{(SUM_W-POS_W+1){strain[POS_W-1]}}, strain};
      mean     = res_neg_ff ? (~div_sts.quo + QUO_W'(1)) : div_sts.quo;
   end

   // divider commands: strain quotient, then the mean
   always_comb begin
      div_cmd = '0;
      case (state_ff)
         S_CHK: begin
            if (!big) begin
               div_cmd.start    = 1'b1;
               div_cmd.steps    = STRAIN_STEPS;
               div_cmd.rem_init = MAG_W'(t_ff[T_W-1:STRAIN_FEED_BITS]);
               div_cmd.feed     = {t_ff[STRAIN_FEED_BITS-1:0],
                                   {(FEED_W-STRAIN_FEED_BITS){1'b0}}};
               div_cmd.den      = apd_ff;
            end
         end
         S_FIN: begin
            if (last_ff && (cnt_ff != '0)) begin
               div_cmd.start    = 1'b1;
               div_cmd.steps    = MEAN_STEPS;
               div_cmd.rem_init = '0;
               div_cmd.feed     = sum_abs;
               div_cmd.den      = MAG_W'(cnt_ff);
            end
         end
         default: div_cmd = '0;
      endcase
   end

   // control sequencer with state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         axis_ff       <= {AXIS_Z_RST, {POS_W{1'b0}}, {POS_W{1'b0}}};
         c_ed_ff       <= '0;
         c_es_ff       <= '0;
         sum_ff        <= '0;
         cnt_ff        <= '0;
         clip_ff       <= 1'b0;
         last_ff       <= 1'b0;
         proj_start_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         proj_start_ff <= 1'b0;

         // configuration writes
         if (csr_we) begin
            case (csr_index)
               CSR_AXIS_X: axis_ff[0] <= csr_wdata;
               CSR_AXIS_Y: axis_ff[1] <= csr_wdata;
               CSR_AXIS_Z: axis_ff[2] <= csr_wdata;
               default:    axis_ff    <= axis_ff;
            endcase
         end

         // result taken downstream; the emit step loads the next one itself
         if (rsp_valid_ff && rsp_tready && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  last_ff <= req_tlast;
                  if (req_tuser == REQ_CENTRE) begin
                     for (int i = 0; i < 3; i++) begin
                        c_ed_ff[i] <= req_tdata[i*POS_W +: POS_W];
                        c_es_ff[i] <= req_tdata[(i+3)*POS_W +: POS_W];
                     end
                     sum_ff  <= '0;
                     cnt_ff  <= '0;
                     clip_ff <= 1'b0;
                     if (req_tlast) begin
                        res_zero_ff  <= 1'b1;
                        res_empty_ff <= 1'b1;
                        state_ff     <= S_EMIT;
                     end
                  end else begin
                     for (int i = 0; i < 3; i++) begin
                        n_ed_ff[i] <= req_tdata[i*POS_W +: POS_W];
                        n_es_ff[i] <= req_tdata[(i+3)*POS_W +: POS_W];
                     end
                     if (cnt_ff >= CNT_W'(MAX_RING)) begin
                        clip_ff  <= 1'b1;
                        state_ff <= S_FIN;
                     end else begin
                        proj_start_ff <= 1'b1;
                        state_ff      <= S_PROJ;
                     end
                  end
               end
            end
            S_PROJ: begin
               if (proj_done) begin
                  if (proj_clip) begin
                     clip_ff <= 1'b1;
                  end
                  state_ff <= S_ABS;
               end
            end
            S_ABS: begin
               apd_ff   <= pd_abs;
               ape_ff   <= pe_abs;
               cnt_ff   <= cnt_ff + CNT_W'(1);
               state_ff <= S_PREP;
            end
            S_PREP: begin
               // skip a neighbour whose projection is near zero
               if ((apd_ff == '0) || (apd_x100 < T_W'(proj_res.len2))) begin
                  state_ff <= S_FIN;
               end else begin
                  neg_ff   <= (ape_ff < apd_ff);
                  mag_ff   <= (ape_ff < apd_ff) ? (apd_ff - ape_ff) : (ape_ff - apd_ff);
                  state_ff <= S_SCALE;
               end
            end
            S_SCALE: begin
               t_ff     <= mag_x100;
               state_ff <= S_CHK;
            end
            S_CHK: begin
               if (big) begin
                  sat_ff   <= 1'b1;
                  clip_ff  <= 1'b1;
                  state_ff <= S_ACC;
               end else begin
                  sat_ff   <= 1'b0;
                  state_ff <= S_SDIV;
               end
            end
            S_SDIV: begin
               if (div_sts.done) begin
                  state_ff <= S_ACC;
               end
            end
            S_ACC: begin
               if (sum_next[SUM_W] != sum_next[SUM_W-1]) begin
                  sum_ff  <= sum_next[SUM_W] ? SUM_MIN : SUM_MAX;
                  clip_ff <= 1'b1;
               end else begin
                  sum_ff <= sum_next[SUM_W-1:0];
               end
               state_ff <= S_FIN;
            end
            S_FIN: begin
               res_empty_ff <= 1'b0;
               res_neg_ff   <= sum_ff[SUM_W-1];
               if (!last_ff) begin
                  state_ff <= S_IDLE;
               end else if (cnt_ff == '0) begin
                  res_zero_ff <= 1'b1;
                  state_ff    <= S_EMIT;
               end else begin
                  res_zero_ff <= 1'b0;
                  state_ff    <= S_MDIV;
               end
            end
            S_MDIV: begin
               if (div_sts.done) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= res_zero_ff ? '0 : mean[POS_W-1:0];
                  rsp_user_ff  <= {clip_ff, res_empty_ff};
                  sum_ff       <= '0;
                  cnt_ff       <= '0;
                  clip_ff      <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/vds_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vds_checker
// Port-level checks of the directional strain block, bound to the top level.
// ----------------------------------------------------------------------------
module vds_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        req_tuser,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [31:0] rsp_tdata,
   input wire [1:0]  rsp_tuser
);

   // a stalled result holds its item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // empty ring reports zero strain and no clipping
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata == 32'd0) && !rsp_tuser[1])
      else $error("empty ring result not zero");

   // a neighbour item keeps the block busy for the next cycle
   a_nb_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> !req_tready)
      else $error("neighbour item did not occupy the block");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind vertex_directional_strain vds_checker u_vds_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
